### design/music_value_to_midi_note_unit_defines.svh
// Assertion helpers for the checker file.
`ifndef MUSIC_VALUE_TO_MIDI_NOTE_UNIT_DEFINES_SVH
`define MUSIC_VALUE_TO_MIDI_NOTE_UNIT_DEFINES_SVH

// Antecedent implies consequent, sampled on the rising clock, off in reset.
`define MVMN_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mvmn assertion failed");

// Condition must never be seen outside reset.
`define MVMN_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("mvmn forbidden condition seen");

`endif

### design/mvmn_pkg.sv
`default_nettype none
package mvmn_pkg;

   localparam int PATTERN_BITS = 24;
   localparam int POS_W        = 5;
   localparam int NOTE_W       = 11;   // signed working width of a note

   localparam logic [7:0]  CHORD_ROOT_RESET    = 8'h00;
   localparam logic [23:0] CHORD_PATTERN_RESET = 24'h000091;
   localparam logic [31:0] SCALE_PATTERN_RESET = 32'h00AB5AB5;

   localparam int SEMIS_PER_OCTAVE = 12;
   localparam int NOTE_MAX         = 127;
   localparam int MISSING_CHORD_ADD = 4;
   // Notes above the top fold into FOLD_BASE .. NOTE_MAX
   localparam int FOLD_BASE   = NOTE_MAX - SEMIS_PER_OCTAVE + 1;
   // floor(x / 12) == (x * RECIP_12) >> RECIP_SHIFT for x below 2048
   localparam int RECIP_12    = 683;
   localparam int RECIP_SHIFT = 13;

   typedef enum logic [1:0] {
      CSR_CHORD_ROOT    = 2'd0,
      CSR_CHORD_PATTERN = 2'd1,
      CSR_SCALE_PATTERN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;    // nth set bit, or last set bit when not found
   } lookup_type;

endpackage
`default_nettype wire

### design/music_value_to_midi_note_unit.sv
`default_nettype none
// Music value to MIDI note converter.
// Input: pulse start with req_music_value and req_fixed; an item is taken at
// every edge where start is high and busy is low. busy is always low, so a
// new item may be given every cycle.
// Output: rsp_valid strobes for one cycle with rsp_midi_note, after the
// stage 1-3 and output registers; items come out in order, one per cycle
// at most. The receiver cannot hold results off and need not.
// Stages: input register; chord tone lookup and base sum; scale tone lookup
// on the shifted scale pattern; octave fold into 0..127.
// Throughput: one item per clock.
// Configuration: csr_write with csr_index / csr_wdata writes chord_root (0),
// chord_pattern (1) or scale_pattern (2); index 3 is ignored. Write only when
// no item is in flight.
// Reset (synchronous, active high) empties the pipeline and loads chord root
// 0, chord pattern 0x000091 and scale pattern 0x00AB5AB5.
module music_value_to_midi_note_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_music_value,
   input  logic        req_fixed,
   output logic        rsp_valid,
   output logic [7:0]  rsp_midi_note,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import mvmn_pkg::*;

   logic [7:0]              chord_root_ff;
   logic [PATTERN_BITS-1:0] chord_pattern_ff;
   logic [31:0]             scale_pattern_ff;

   logic        s1_valid_ff;
   logic [15:0] s1_value_ff;
   logic        s1_fixed_ff;

   logic                     s2_valid_ff;
   logic                     s2_fixed_ff;
   logic [7:0]               s2_low_ff;
   logic [3:0]               s2_stone_ff;
   logic [POS_W-1:0]         s2_chord_off_ff;
   logic signed [NOTE_W-1:0] s2_partial_ff;
   logic signed [NOTE_W-1:0] s2_partial_in;

   logic                     s3_valid_ff;
   logic                     s3_fixed_ff;
   logic [7:0]               s3_low_ff;
   logic signed [NOTE_W-1:0] s3_note_ff;
   logic signed [NOTE_W-1:0] s3_note_in;

   logic       rsp_valid_ff;
   logic [7:0] rsp_note_ff;
   logic [7:0] rsp_note_in;

   lookup_type              chord_hit;
   lookup_type              scale_hit;
   logic [31:0]             scale_shifted;
   logic [9:0]              base;
   logic [POS_W-1:0]        chord_add;
   logic [7:0]              folded;

   assign busy = 1'b0;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chord_root_ff    <= CHORD_ROOT_RESET;
         chord_pattern_ff <= CHORD_PATTERN_RESET;
         scale_pattern_ff <= SCALE_PATTERN_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_CHORD_ROOT:    chord_root_ff    <= csr_wdata[7:0];
            CSR_CHORD_PATTERN: chord_pattern_ff <= csr_wdata[PATTERN_BITS-1:0];
            CSR_SCALE_PATTERN: scale_pattern_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: capture the item
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_value_ff <= req_music_value;
      s1_fixed_ff <= req_fixed;
   end

   // stage 2: chord tone lookup, root + octave + chord + accidental
   mvmn_lookup u_chord_lookup (
      .pattern (chord_pattern_ff),
      .index   (s1_value_ff[11:8]),
      .result  (chord_hit)
   );

   always_comb begin
      base      = 10'(chord_root_ff) + 10'(s1_value_ff[15:12]) * 10'(SEMIS_PER_OCTAVE);
      chord_add = chord_hit.found ? chord_hit.pos
                                  : chord_hit.pos + POS_W'(MISSING_CHORD_ADD);
      s2_partial_in = $signed({1'b0, base})
                    + $signed({{(NOTE_W-POS_W){1'b0}}, chord_add})
                    + $signed({{(NOTE_W-4){s1_value_ff[3]}}, s1_value_ff[3:0]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_fixed_ff     <= s1_fixed_ff;
      s2_low_ff       <= s1_value_ff[7:0];
      s2_stone_ff     <= s1_value_ff[7:4];
      s2_chord_off_ff <= chord_hit.pos;
      s2_partial_ff   <= s2_partial_in;
   end

   // stage 3: scale tone lookup above the chord tone
   assign scale_shifted = scale_pattern_ff >> s2_chord_off_ff;

   mvmn_lookup u_scale_lookup (
      .pattern (scale_shifted[PATTERN_BITS-1:0]),
      .index   (s2_stone_ff),
      .result  (scale_hit)
   );

   always_comb begin
      if (s2_stone_ff != 4'd0 && scale_hit.found) begin
         s3_note_in = s2_partial_ff + $signed({{(NOTE_W-POS_W){1'b0}}, scale_hit.pos});
      end else begin
         s3_note_in = s2_partial_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_fixed_ff <= s2_fixed_ff;
      s3_low_ff   <= s2_low_ff;
      s3_note_ff  <= s3_note_in;
   end

   // stage 4: fold into range, fixed items pass the low byte
   mvmn_fold u_fold (
      .note      (s3_note_ff),
      .midi_note (folded)
   );

   assign rsp_note_in = s3_fixed_ff ? s3_low_ff : folded;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s3_valid_ff;
      end
      rsp_note_ff <= rsp_note_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_midi_note = rsp_note_ff;

endmodule
`default_nettype wire

### design/mvmn_lookup.sv
`default_nettype none
// Finds the nth set bit of a 24-bit tone pattern.
module mvmn_lookup (
   input  logic [mvmn_pkg::PATTERN_BITS-1:0] pattern,
   input  logic [3:0]                        index,
   output mvmn_pkg::lookup_type              result
);
   import mvmn_pkg::*;

   logic [PATTERN_BITS-1:0] hit;
   logic [PATTERN_BITS-1:0] last;
   logic [POS_W-1:0]        pos_hit;
   logic [POS_W-1:0]        pos_last;

   // per-bit tests: set bits below i counted independently for each i
   always_comb begin
      for (int i = 0; i < PATTERN_BITS; i++) begin
         hit[i]  = pattern[i] &&
                   (POS_W'($countones(pattern & ((PATTERN_BITS'(1) << i) - 1'b1)))
                    == {1'b0, index});
         last[i] = pattern[i] && ((pattern >> i) >> 1) == '0;
      end
   end

   // encode the one-hot hit vectors
   always_comb begin
      pos_hit  = '0;
      pos_last = '0;
      for (int i = 0; i < PATTERN_BITS; i++) begin
         if (hit[i]) pos_hit = pos_hit | POS_W'(i);
         if (last[i]) pos_last = pos_last | POS_W'(i);
      end
      result.found = |hit;
      result.pos   = (|hit) ? pos_hit : pos_last;
   end

endmodule
`default_nettype wire

### design/mvmn_fold.sv
`default_nettype none
// Folds a note into 0..127 by steps of an octave.
module mvmn_fold (
   input  logic signed [mvmn_pkg::NOTE_W-1:0] note,
   output logic        [7:0]                  midi_note
);
   import mvmn_pkg::*;

   logic [8:0]  excess;
   logic [18:0] product;
   logic [4:0]  quotient;
   logic [3:0]  remainder;

   // remainder of (note - FOLD_BASE) by 12 through a reciprocal multiply
   always_comb begin
      excess    = note[8:0] - 9'(FOLD_BASE);
      product   = 19'(excess) * 19'(RECIP_12);
      quotient  = product[RECIP_SHIFT +: 5];
      remainder = 4'(excess - 9'(quotient) * 9'(SEMIS_PER_OCTAVE));
   end

   // below zero one octave up suffices (lowest sum is -8)
   always_comb begin
      if (note < 0) begin
         midi_note = 8'(note + NOTE_W'(SEMIS_PER_OCTAVE));
      end else if (note > NOTE_W'(NOTE_MAX)) begin
         midi_note = 8'(FOLD_BASE) + 8'(remainder);
      end else begin
         midi_note = note[7:0];
      end
   end

endmodule
`default_nettype wire

### design/mvmn_checker.sv
`default_nettype none
`include "music_value_to_midi_note_unit_defines.svh"
// Port-level checks on the converter.
module mvmn_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [15:0] req_music_value,
   input logic        req_fixed,
   input logic        rsp_valid,
   input logic [7:0]  rsp_midi_note
);

   // the pipeline never pushes back
   `MVMN_ASSERT_NEVER(a_never_busy, clock, reset, busy)

   // every taken item comes out as a result
   `MVMN_ASSERT_IMPL(a_latency, clock, reset, start && !busy, ##4 rsp_valid)

   // no result without an earlier taken item
   `MVMN_ASSERT_IMPL(a_no_spurious, clock, reset, rsp_valid, $past(start && !busy, 4))

   // fixed items pass their low byte
   `MVMN_ASSERT_IMPL(a_fixed_pass, clock, reset, rsp_valid && $past(req_fixed, 4), rsp_midi_note == $past(req_music_value[7:0], 4))

   // folded notes stay in MIDI range
   `MVMN_ASSERT_IMPL(a_note_range, clock, reset, rsp_valid && !$past(req_fixed, 4), rsp_midi_note <= 8'd127)

endmodule

bind music_value_to_midi_note_unit mvmn_checker u_mvmn_checker (.*);
`default_nettype wire

### tb/tb_music_value_to_midi_note_unit.sv
`timescale 1ns / 1ps
module tb_music_value_to_midi_note_unit;
   import mvmn_pkg::*;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_PHASES = 13;
   localparam int PHASE_ITEMS   = 125;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct {
      logic [15:0] value;
      logic        pass;
      logic [7:0]  note;
   } note_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_music_value = '0;
   logic        req_fixed = 1'b0;
   logic        rsp_valid;
   logic [7:0]  rsp_midi_note;
   logic        csr_write = 1'b0;
   csr_index_type csr_index = CSR_CHORD_ROOT;
   logic [31:0] csr_wdata = '0;

   // shadow copy of the configuration registers
   logic [7:0]  cfg_root  = CHORD_ROOT_RESET;
   logic [23:0] cfg_chord = CHORD_PATTERN_RESET;
   logic [31:0] cfg_scale = SCALE_PATTERN_RESET;

   note_item_type pending_values[$];
   note_item_type expected_notes[$];
   note_item_type driven_item;
   note_item_type oldest;

   int gap_limit = 0;
   int idle_left = 0;
   int cycle_count = 0;
   int error_count = 0;
   int accepted_count = 0;
   int pass_count = 0;
   int checked_count = 0;
   int setting_count = 0;

   music_value_to_midi_note_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_music_value (req_music_value),
      .req_fixed       (req_fixed),
      .rsp_valid       (rsp_valid),
      .rsp_midi_note   (rsp_midi_note),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // n-th set bit among the low 24 bits; pos keeps the last set bit seen
   function automatic lookup_type find_nth_tone(int unsigned n, logic [31:0] pattern);
      lookup_type hit;
      int unsigned seen;
      hit  = '0;
      seen = 0;
      for (int i = 0; i < PATTERN_BITS; i++) begin
         if (pattern[i] && !hit.found) begin
            hit.pos = POS_W'(i);
            if (seen == n) hit.found = 1'b1;
            seen++;
         end
      end
      return hit;
   endfunction

   function automatic logic [7:0] predict_midi_note(logic [15:0] value, logic pass);
      lookup_type chord_hit;
      lookup_type scale_hit;
      int note;
      if (pass) return value[7:0];
      note = int'(cfg_root) + SEMIS_PER_OCTAVE * int'(value[15:12]);
      chord_hit = find_nth_tone(int'(value[11:8]), {8'h00, cfg_chord});
      note += int'(chord_hit.pos);
      if (!chord_hit.found) note += MISSING_CHORD_ADD;
      // scale lookup is re-based at the chord tone
      if (value[7:4] != 4'd0) begin
         scale_hit = find_nth_tone(int'(value[7:4]), cfg_scale >> chord_hit.pos);
         if (scale_hit.found) note += int'(scale_hit.pos);
      end
      note += int'($signed(value[3:0]));
      while (note < 0) note += SEMIS_PER_OCTAVE;
      while (note > NOTE_MAX) note -= SEMIS_PER_OCTAVE;
      return note[7:0];
   endfunction

   // driver: one item per start pulse, random gap after each accepted item
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            driven_item.note = predict_midi_note(driven_item.value, driven_item.pass);
            expected_notes.insert(expected_notes.size(), driven_item);
            accepted_count++;
            if (driven_item.pass) pass_count++;
            idle_left = int'($urandom_range(0, gap_limit));
         end
         if (idle_left == 0 && pending_values.size() != 0) begin
            driven_item = pending_values.pop_front();
            req_music_value <= driven_item.value;
            req_fixed       <= driven_item.pass;
            start           <= 1'b1;
         end else begin
            if (idle_left > 0) idle_left--;
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe must match the oldest predicted note
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_notes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected note: expected none, actual %0d", $time, rsp_midi_note);
         end else begin
            oldest = expected_notes.pop_front();
            checked_count++;
            if (rsp_midi_note !== oldest.note) begin
               error_count++;
               $display("%0t: note for value %h fixed %0b: expected %0d, actual %0d",
                        $time, oldest.value, oldest.pass, oldest.note, rsp_midi_note);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_CHORD_ROOT:    cfg_root  = data[7:0];
         CSR_CHORD_PATTERN: cfg_chord = data[23:0];
         CSR_SCALE_PATTERN: cfg_scale = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [7:0] root, input logic [23:0] chord,
                            input logic [31:0] scale);
      write_reg(CSR_CHORD_ROOT, {24'h0, root});
      write_reg(CSR_CHORD_PATTERN, {8'h0, chord});
      write_reg(CSR_SCALE_PATTERN, scale);
      setting_count++;
   endtask

   task automatic add_item(input logic [15:0] value, input logic pass);
      note_item_type item;
      item.value = value;
      item.pass  = pass;
      item.note  = '0;
      pending_values.insert(pending_values.size(), item);
   endtask

   task automatic wait_idle();
      while (start || pending_values.size() != 0 || expected_notes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // extremes, sparse and dense register values
   function automatic logic [31:0] pick_pattern(logic [31:0] mask);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return mask;
         2, 3:    return $urandom & $urandom & mask;
         default: return $urandom & mask;
      endcase
   endfunction

   initial begin
      logic [15:0] value;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      setting_count = 1;

      // reset settings: chord tones at 0, 4, 7
      gap_limit = 19;
      add_item(16'h0000, 1'b0);
      add_item(16'hFFFF, 1'b0);
      add_item(16'h00FF, 1'b1);
      add_item(16'hFF80, 1'b1);
      add_item(16'h0000, 1'b1);
      add_item(16'h0008, 1'b0);   // negative sum folds up
      add_item(16'h0007, 1'b0);
      add_item(16'h0300, 1'b0);   // chord tone absent
      add_item(16'h0100, 1'b0);
      add_item(16'h0210, 1'b0);
      add_item(16'h02F0, 1'b0);   // scale tone absent
      add_item(16'hF000, 1'b0);   // high octave folds down
      add_item(16'h5A3C, 1'b0);
      wait_idle();

      // empty patterns, top root
      gap_limit = 0;
      configure(8'hFF, 24'h000000, 32'h00000000);
      add_item(16'h0000, 1'b0);
      add_item(16'h0F00, 1'b0);
      add_item(16'h0010, 1'b0);
      add_item(16'hF7F7, 1'b0);
      add_item(16'h0008, 1'b0);
      wait_idle();

      // full patterns
      gap_limit = 19;
      configure(8'h00, 24'hFFFFFF, 32'hFFFFFFFF);
      add_item(16'h0F00, 1'b0);
      add_item(16'h0FF0, 1'b0);
      add_item(16'h0FF8, 1'b0);
      add_item(16'hFFFF, 1'b0);
      add_item(16'h1788, 1'b0);
      wait_idle();

      // random settings and items
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         gap_limit = (p % 3 == 0) ? 0 : 19;
         configure(8'(pick_pattern(32'hFF)), 24'(pick_pattern(32'hFFFFFF)),
                   pick_pattern(32'hFFFFFFFF));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            value = 16'($urandom);
            // favor chord tones that usually exist
            if ($urandom_range(0, 1) == 0) value[11:8] = 4'($urandom_range(0, 7));
            add_item(value, $urandom_range(0, 3) == 0);
         end
         wait_idle();
      end

      $display("%0d items (%0d pass-through) over %0d register settings, %0d notes checked",
               accepted_count, pass_count, setting_count, checked_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
